[rtl/core/fwrs_pkg.sv]
// fwrs_pkg: shared types and constants of the fixed-width run segmenter
// no dependencies
`default_nettype none

package fwrs_pkg;

  localparam int unsigned BUF_DEPTH  = 32;
  localparam int unsigned PAIR_LIMIT = 20;
  localparam int unsigned APB_AW     = 4;
  localparam int unsigned APB_DW     = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_GOOD_RATIO = 2'd0;
  localparam reg_idx_t REG_MIN_RUN    = 2'd1;
  localparam reg_idx_t REG_SEPARATOR  = 2'd2;

  localparam logic [8:0]  GOOD_RATIO_RST = 9'd192;
  localparam logic [5:0]  MIN_RUN_RST    = 6'd2;
  localparam logic [31:0] SEPARATOR_RST  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    KIND_BASE       = 3'd0,
    KIND_SEP        = 3'd1,
    KIND_RUN_GAP    = 3'd2,
    KIND_COUNT      = 3'd3,
    KIND_WIDTH      = 3'd4,
    KIND_RUN_VAL    = 3'd5,
    KIND_SINGLE_GAP = 3'd6,
    KIND_SINGLE_VAL = 3'd7
  } kind_t;

  typedef struct packed {
    logic [8:0]  good_ratio;
    logic [5:0]  min_run_length;
    logic [31:0] separator_word;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CLOSE,
    ST_SEP,
    ST_GAP,
    ST_CNT,
    ST_WID,
    ST_HVAL,
    ST_PGAP,
    ST_PVAL,
    ST_OPEN
  } state_t;

endpackage

`default_nettype wire

[rtl/core/fwrs_if.sv]
// fwrs_item_if, fwrs_token_if: valid/ready channels of the run segmenter
// depends on fwrs_pkg
`default_nettype none

interface fwrs_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] doc_id;
  logic [31:0] doc_len;
  logic        final_item;

  modport source (output valid, doc_id, doc_len, final_item, input ready);
  modport sink   (input valid, doc_id, doc_len, final_item, output ready);
endinterface

interface fwrs_token_if;
  import fwrs_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  kind_t       kind;
  logic        burst_end;

  modport source (output valid, word, kind, burst_end, input ready);
  modport sink   (input valid, word, kind, burst_end, output ready);
endinterface

`default_nettype wire

[rtl/core/fixed_width_run_segmenter.sv]
// fixed_width_run_segmenter: top level, apb registers and run sequencer
// flow: a pair is accepted, then decided; no new pair is taken until the state is idle
// again; opening a list emits the base token in the decide state, and a breaking pair
// reopens a run after the close; closing an n-entry run emits separator, gap, count,
// width and n values in header form or a gap and a value per entry in pair form
// reset: synchronous rst clears the run state and registers; the buffer is not cleared
`default_nettype none

module fixed_width_run_segmenter #(
  parameter int unsigned MAX_RUN = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [fwrs_pkg::APB_AW-1:0]  paddr,
  input  wire  [fwrs_pkg::APB_DW-1:0]  pwdata,
  output logic [fwrs_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  fwrs_item_if.sink                    item,
  fwrs_token_if.source                 res
);
  import fwrs_pkg::*;

  cfg_t cfg;

  fwrs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fwrs_ctrl #(
    .MAX_RUN (MAX_RUN)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .res  (res)
  );

endmodule

`default_nettype wire

[rtl/core/fwrs_cfg.sv]
// fwrs_cfg: apb register file holding ratio, minimum run length and separator
// depends on fwrs_pkg
`default_nettype none

module fwrs_cfg (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [fwrs_pkg::APB_AW-1:0]  paddr,
  input  wire  [fwrs_pkg::APB_DW-1:0]  pwdata,
  output logic [fwrs_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output fwrs_pkg::cfg_t               cfg
);
  import fwrs_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.good_ratio     <= GOOD_RATIO_RST;
      cfg.min_run_length <= MIN_RUN_RST;
      cfg.separator_word <= SEPARATOR_RST;
    end else if (wr) begin
      unique case (idx)
        REG_GOOD_RATIO: cfg.good_ratio     <= pwdata[8:0];
        REG_MIN_RUN:    cfg.min_run_length <= pwdata[5:0];
        REG_SEPARATOR:  cfg.separator_word <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GOOD_RATIO: prdata = 32'(cfg.good_ratio);
      REG_MIN_RUN:    prdata = 32'(cfg.min_run_length);
      REG_SEPARATOR:  prdata = cfg.separator_word;
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/fwrs_ctrl.sv]
// fwrs_ctrl: run buffer memory, run state and token sequencer with output register
// depends on fwrs_pkg and fwrs_if
`default_nettype none

module fwrs_ctrl #(
  parameter int unsigned MAX_RUN = 32
) (
  input  wire             clk,
  input  wire             rst,
  input  fwrs_pkg::cfg_t  cfg,
  fwrs_item_if.sink       item,
  fwrs_token_if.source    res
);
  import fwrs_pkg::*;

  localparam int unsigned DEPTH = (MAX_RUN > BUF_DEPTH) ? BUF_DEPTH : MAX_RUN;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  function automatic logic [2:0] byte_width(input logic [31:0] v);
    if (v[31:24] != 8'd0)      return 3'd4;
    else if (v[23:16] != 8'd0) return 3'd3;
    else if (v[15:8] != 8'd0)  return 3'd2;
    else                       return 3'd1;
  endfunction

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;

  state_t      state, state_next;
  logic [31:0] cur_id, cur_len;
  logic        cur_fin;
  logic [2:0]  cur_w;
  logic        reopen;
  logic        started;
  logic [CW-1:0] run_count;
  logic [31:0] run_first_id, prev_id, prev_end_id;
  logic [2:0]  run_width;
  logic [7:0]  pad_bytes, fit_bytes;
  logic [AW-1:0] idx, idx_next;

  logic        out_valid;
  logic [31:0] out_word;
  kind_t       out_kind;
  logic        out_last;

  logic        slot_free, new_list, extend_ok, idx_last, hdr, close_last;
  logic [8:0]  u_sum, g_sum;
  logic [17:0] need, have;
  logic [5:0]  lim;
  logic        emit, emit_last;
  logic [31:0] emit_word;
  kind_t       emit_kind;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic        accept, do_open, close_done;

  assign slot_free  = !out_valid || res.ready;
  assign accept     = item.valid && item.ready;
  assign new_list   = !started || (run_count == '0);
  assign u_sum      = 9'(pad_bytes) + 9'(run_width);
  assign g_sum      = 9'(fit_bytes) + 9'(cur_w);
  assign need       = 18'(cfg.good_ratio) * 18'(u_sum);
  assign have       = 18'({g_sum, 8'h00});
  assign extend_ok  = (cur_id == prev_id + 32'd1) && (cur_w <= run_width)
                      && (run_count < CW'(DEPTH)) && (have >= need);
  assign lim        = (cfg.min_run_length > 6'(PAIR_LIMIT)) ? 6'(PAIR_LIMIT)
                                                            : cfg.min_run_length;
  assign hdr        = 6'(run_count) > lim;
  assign idx_last   = (CW'(idx) + CW'(1)) == run_count;
  assign close_last = !(reopen && cur_fin);
  assign close_done = slot_free && idx_last && (state == ST_HVAL || state == ST_PVAL);
  assign do_open    = (state == ST_DECIDE && new_list && slot_free) || state == ST_OPEN;

  assign item.ready    = (state == ST_IDLE);
  assign res.valid     = out_valid;
  assign res.word      = out_word;
  assign res.kind      = out_kind;
  assign res.burst_end = out_last;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (item.valid) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (new_list) begin
          if (slot_free) state_next = cur_fin ? ST_CLOSE : ST_IDLE;
        end else if (extend_ok) begin
          state_next = cur_fin ? ST_CLOSE : ST_IDLE;
        end else begin
          state_next = ST_CLOSE;
        end
      end
      ST_CLOSE:  state_next = hdr ? ST_SEP : ST_PGAP;
      ST_SEP:    if (slot_free) state_next = ST_GAP;
      ST_GAP:    if (slot_free) state_next = ST_CNT;
      ST_CNT:    if (slot_free) state_next = ST_WID;
      ST_WID:    if (slot_free) state_next = ST_HVAL;
      ST_HVAL:   if (close_done) state_next = reopen ? ST_OPEN : ST_IDLE;
      ST_PGAP:   if (slot_free) state_next = ST_PVAL;
      ST_PVAL: begin
        if (close_done) state_next = reopen ? ST_OPEN : ST_IDLE;
        else if (slot_free) state_next = ST_PGAP;
      end
      ST_OPEN:   state_next = cur_fin ? ST_CLOSE : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    emit      = 1'b0;
    emit_word = '0;
    emit_kind = KIND_BASE;
    emit_last = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    idx_next  = idx;
    unique case (state)
      ST_DECIDE: begin
        if (new_list) begin
          emit      = slot_free;
          emit_word = cur_id;
          emit_kind = KIND_BASE;
          emit_last = !cur_fin;
          mem_we    = slot_free;
        end else if (extend_ok) begin
          mem_we    = 1'b1;
          mem_waddr = run_count[AW-1:0];
        end
      end
      ST_CLOSE: idx_next = '0;
      ST_SEP: begin
        emit      = slot_free;
        emit_word = cfg.separator_word;
        emit_kind = KIND_SEP;
      end
      ST_GAP: begin
        emit      = slot_free;
        emit_word = run_first_id - prev_end_id;
        emit_kind = KIND_RUN_GAP;
      end
      ST_CNT: begin
        emit      = slot_free;
        emit_word = 32'(run_count);
        emit_kind = KIND_COUNT;
      end
      ST_WID: begin
        emit      = slot_free;
        emit_word = 32'(run_width);
        emit_kind = KIND_WIDTH;
      end
      ST_HVAL: begin
        emit      = slot_free;
        emit_word = rdata;
        emit_kind = KIND_RUN_VAL;
        emit_last = idx_last && close_last;
        if (slot_free) idx_next = idx + AW'(1);
      end
      ST_PGAP: begin
        emit      = slot_free;
        emit_word = (idx == '0) ? (run_first_id - prev_end_id) : 32'd1;
        emit_kind = KIND_SINGLE_GAP;
      end
      ST_PVAL: begin
        emit      = slot_free;
        emit_word = rdata;
        emit_kind = KIND_SINGLE_VAL;
        emit_last = idx_last && close_last;
        if (slot_free) idx_next = idx + AW'(1);
      end
      ST_OPEN:   mem_we = 1'b1;
      default: ;
    endcase
  end

  // run buffer, registered read addressed by the next index, write forwarded
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= cur_len;
    rdata <= (mem_we && mem_waddr == idx_next) ? cur_len : mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      started      <= 1'b0;
      run_count    <= '0;
      reopen       <= 1'b0;
      out_valid    <= 1'b0;
      idx          <= '0;
      run_first_id <= '0;
      prev_id      <= '0;
      prev_end_id  <= '0;
      run_width    <= '0;
      pad_bytes    <= '0;
      fit_bytes    <= '0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= emit || (out_valid && !res.ready);
      if (state == ST_DECIDE && !new_list) begin
        reopen <= !extend_ok;
        if (extend_ok) begin
          run_count <= run_count + CW'(1);
          prev_id   <= cur_id;
          pad_bytes <= u_sum[7:0];
          fit_bytes <= g_sum[7:0];
        end
      end
      if (do_open) begin
        run_count    <= CW'(1);
        reopen       <= 1'b0;
        run_first_id <= cur_id;
        prev_id      <= cur_id;
        run_width    <= cur_w;
        pad_bytes    <= '0;
        fit_bytes    <= '0;
      end
      if (state == ST_DECIDE && new_list && slot_free) begin
        started     <= 1'b1;
        prev_end_id <= cur_id;
      end
      if (close_done) begin
        run_count   <= '0;
        prev_end_id <= run_first_id + 32'(run_count) - 32'd1;
        if (!reopen) started <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_id  <= item.doc_id;
      cur_len <= item.doc_len;
      cur_fin <= item.final_item;
      cur_w   <= byte_width(item.doc_len);
    end
    if (emit) begin
      out_word <= emit_word;
      out_kind <= emit_kind;
      out_last <= emit_last;
    end
  end

endmodule

`default_nettype wire
